@@ hdl/vzcp_pkg.sv @@
// ----------------------------------------------------------------------------
// vzcp_pkg
// Types and constants shared by the vertex transform, z clip and projection
// block.
// ----------------------------------------------------------------------------
package vzcp_pkg;

    typedef enum logic [1:0] {
        ST_VISIBLE = 2'd0,
        ST_CLIPPED = 2'd1,
        ST_ZERO_W  = 2'd2
    } status_t;

    localparam int DIV_STEPS = 32;
    localparam int HW        = 34;
    localparam int MW        = 33;

    localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [63:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [63:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [63:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

@@ hdl/vertex_z_clip_project.sv @@
// ----------------------------------------------------------------------------
// vertex_z_clip_project
// Transforms a Q8.8 point by a 4x4 Q4.12 matrix, clips on z, divides by w.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while the output is taken; the three
// 32-step divider pipelines set the depth, one restoring step per stage.
// The whole pipeline holds when the output item is not taken.
// Reset clears all valid bits and loads the identity matrix.
module vertex_z_clip_project (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // point_x, point_y, point_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // proj_x, proj_y, proj_z
    output logic [1:0]   m_tuser    // status
);

    localparam int NS = vzcp_pkg::DIV_STEPS;
    localparam int HW = vzcp_pkg::HW;
    localparam int MW = vzcp_pkg::MW;

    logic [63:0] row_reg [4];

    logic advance;

    logic               v1_reg;
    logic signed [31:0] prod_reg  [4][3];
    logic signed [15:0] trans_reg [4];

    logic                 v2_reg;
    logic signed [HW-1:0] h_reg [4];

    logic              dv_reg     [NS+1];
    vzcp_pkg::status_t dst_reg    [NS+1];
    logic [MW-1:0]     dw_reg     [NS+1];
    logic [MW-1:0]     dr_reg     [NS+1][3];
    logic [31:0]       dlo_reg    [NS+1][3];
    logic [31:0]       dq_reg     [NS+1][3];
    logic              dneg_reg   [NS+1][3];
    logic              dovf_reg   [NS+1][3];

    logic              vo_reg;
    vzcp_pkg::status_t sto_reg;
    logic [31:0]       po_reg [3];

    logic signed [HW:0]   clip_sum;
    logic [HW-1:0]        abs_v [3];
    vzcp_pkg::status_t    st_next;
    logic [MW-1:0]        dr_next  [NS][3];
    logic                 ge_next  [NS][3];
    logic [31:0]          po_next  [3];

    assign advance  = !vo_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = vo_reg;
    assign m_tuser  = sto_reg;
    assign m_tdata  = {po_reg[2], po_reg[1], po_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= vzcp_pkg::ROW0_RESET;
            row_reg[1] <= vzcp_pkg::ROW1_RESET;
            row_reg[2] <= vzcp_pkg::ROW2_RESET;
            row_reg[3] <= vzcp_pkg::ROW3_RESET;
        end
        else if (cfg_we)
        begin
            row_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        clip_sum = {h_reg[2][HW-1], h_reg[2]} + {h_reg[3][HW-1], h_reg[3]};
        if (clip_sum[HW] || (!h_reg[2][HW-1] && (h_reg[2] != '0)))
        begin
            st_next = vzcp_pkg::ST_CLIPPED;
        end
        else if (h_reg[3] == '0)
        begin
            st_next = vzcp_pkg::ST_ZERO_W;
        end
        else
        begin
            st_next = vzcp_pkg::ST_VISIBLE;
        end
        for (int l = 0; l < 3; l++)
        begin
            abs_v[l] = h_reg[l][HW-1] ? HW'(-h_reg[l]) : HW'(h_reg[l]);
        end
    end

    always_comb
    begin
        logic [MW:0] t;
        for (int k = 0; k < NS; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                t = {dr_reg[k][l], dlo_reg[k][l][31]};
                ge_next[k][l] = (t >= {1'b0, dw_reg[k]});
                dr_next[k][l] = ge_next[k][l] ? MW'(t - {1'b0, dw_reg[k]}) : MW'(t);
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dst_reg[NS] != vzcp_pkg::ST_VISIBLE)
            begin
                po_next[l] = '0;
            end
            else if (!dneg_reg[NS][l])
            begin
                po_next[l] = (dovf_reg[NS][l] || dq_reg[NS][l][31]) ?
                             vzcp_pkg::SAT_POS : dq_reg[NS][l];
            end
            else
            begin
                po_next[l] = (dovf_reg[NS][l] || (dq_reg[NS][l] > vzcp_pkg::SAT_NEG)) ?
                             vzcp_pkg::SAT_NEG : (~dq_reg[NS][l] + 32'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int k = 0; k < NS; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
            vo_reg <= dv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= $signed(row_reg[r][16*c +: 16]) *
                                      $signed(s_tdata[16*c +: 16]);
                end
                trans_reg[r] <= $signed(row_reg[r][63:48]);
                h_reg[r] <= HW'(prod_reg[r][0]) + HW'(prod_reg[r][1]) +
                            HW'(prod_reg[r][2]) + (HW'(trans_reg[r]) <<< 8);
            end

            dst_reg[0] <= st_next;
            dw_reg[0]  <= h_reg[3][MW-1:0];
            for (int l = 0; l < 3; l++)
            begin
                dr_reg[0][l]   <= MW'(abs_v[l][MW-1:16]);
                dlo_reg[0][l]  <= {abs_v[l][15:0], 16'd0};
                dq_reg[0][l]   <= '0;
                dneg_reg[0][l] <= h_reg[l][HW-1];
                dovf_reg[0][l] <= (MW'(abs_v[l][MW-1:16]) >= h_reg[3][MW-1:0]);
            end

            for (int k = 0; k < NS; k++)
            begin
                dst_reg[k+1] <= dst_reg[k];
                dw_reg[k+1]  <= dw_reg[k];
                for (int l = 0; l < 3; l++)
                begin
                    dr_reg[k+1][l]   <= dr_next[k][l];
                    dlo_reg[k+1][l]  <= {dlo_reg[k][l][30:0], 1'b0};
                    dq_reg[k+1][l]   <= {dq_reg[k][l][30:0], ge_next[k][l]};
                    dneg_reg[k+1][l] <= dneg_reg[k][l];
                    dovf_reg[k+1][l] <= dovf_reg[k][l];
                end
            end

            sto_reg <= dst_reg[NS];
            for (int l = 0; l < 3; l++)
            begin
                po_reg[l] <= po_next[l];
            end
        end
    end

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != vzcp_pkg::ST_VISIBLE)) |-> (m_tdata == '0))
        else $error("non-visible item carries nonzero data");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(v1_reg) && $stable(v2_reg) && $stable(dv_reg[NS])))
        else $error("pipeline moved during a stall");

    a_visible_w: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[0] && (dst_reg[0] == vzcp_pkg::ST_VISIBLE)) |-> (dw_reg[0] != '0))
        else $error("visible item with zero divisor");

endmodule
